@@ rtl/array_lifo_stack_assert.svh @@
// Assertion macros for the LIFO stack.
// ALS_ASSERT:      antecedent holds in the same cycle as the consequent.
// ALS_ASSERT_NEXT: consequent is checked in the cycle after the antecedent.
`ifndef ARRAY_LIFO_STACK_ASSERT_SVH
`define ARRAY_LIFO_STACK_ASSERT_SVH

`ifndef SYNTH
`define ALS_ASSERT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stack assertion failed");
`define ALS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stack assertion failed");
`else
`define ALS_ASSERT(lbl, clk, rst, ante, cons)
`define ALS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

@@ rtl/alst_pkg.sv @@
package alst_pkg;

  localparam int unsigned WordW = 32;

  // Operation codes carried in the mode field
  localparam logic [2:0] MODE_PUSH    = 3'd0;
  localparam logic [2:0] MODE_POP     = 3'd1;
  localparam logic [2:0] MODE_PEEK    = 3'd2;
  localparam logic [2:0] MODE_SEARCH  = 3'd3;
  localparam logic [2:0] MODE_DISPLAY = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  // What every cell does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,  // take the word from the cell above
    CELL_POP,   // take the word from the cell below
    CELL_ROT    // as pop, but the tail cell takes the top word
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     tail;   // this cell holds the bottom-most stored word
    logic     valid;  // this cell holds a stored word
  } cell_ctl_t;

endpackage

@@ rtl/alst_in_if.sv @@
interface alst_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic signed [31:0] operand;

  modport source (output valid, output mode, output operand, input ready);
  modport sink   (input valid, input mode, input operand, output ready);
endinterface

@@ rtl/alst_out_if.sv @@
interface alst_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] data_out;
  logic               found;
  logic               last;
  logic [3:0]         depth;
  logic               is_empty;
  logic               is_full;

  modport source (output valid, output status, output data_out, output found,
                  output last, output depth, output is_empty, output is_full,
                  input ready);
  modport sink   (input valid, input status, input data_out, input found,
                  input last, input depth, input is_empty, input is_full,
                  output ready);
endinterface

@@ rtl/alst_cell.sv @@
module alst_cell (
  input  logic                        clk,
  input  alst_pkg::cell_ctl_t         ctl,
  input  logic [alst_pkg::WordW-1:0]  up_data,
  input  logic [alst_pkg::WordW-1:0]  down_data,
  input  logic [alst_pkg::WordW-1:0]  wrap_data,
  input  logic [alst_pkg::WordW-1:0]  key,
  output logic [alst_pkg::WordW-1:0]  data,
  output logic                        match
);
  import alst_pkg::*;

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      CELL_HOLD: data <= data;
      CELL_PUSH: data <= up_data;
      CELL_POP:  data <= down_data;
      CELL_ROT:  data <= ctl.tail ? wrap_data : down_data;
      default:   data <= data;
    endcase
  end

  assign match = ctl.valid && (data == key);

endmodule

@@ rtl/array_lifo_stack.sv @@
// Bounded LIFO stack of signed 32-bit words held in a chain of DEPTH cells,
// top of stack always in cell 0. Push shifts the chain down, pop shifts it
// up, so push, pop, peek and search each take one input word per cycle
// unless the output stalls, and give one result word. Search compares
// every stored cell against the operand at once and ORs the hits. Display
// gives one result word per stored entry, top first, by rotating the stored
// part of the chain one place per cycle through cell 0 while the sink takes
// results; it holds off new commands until its last result is registered
// and leaves the stack as it was. A display of an empty stack, like pop,
// peek or search on it, gives a single underflow result; a push onto a full
// stack gives an overflow result and changes nothing. Mode codes 5 to 7 are
// taken and dropped with no result. Results sit in an output register; a
// new word is taken once that register is free or being emptied in the same
// cycle. No clearing pass follows reset: cell contents are not reset.
`include "array_lifo_stack_assert.svh"

module array_lifo_stack #(
  parameter int unsigned DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst,
  alst_in_if.sink    cmd,
  alst_out_if.source rsp
);
  import alst_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_DISP
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [CW-1:0]   rem;       // display results still to give

  logic [WordW-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0] cell_match;
  cell_op_t         op;

  logic accept;
  logic advance;   // output register free for a new result
  logic empty;
  logic full;
  logic hit;

  // output register
  logic             o_valid;
  logic [1:0]       o_status;
  logic [WordW-1:0] o_data;
  logic             o_found;
  logic             o_last;
  logic [3:0]       o_depth;
  logic             o_empty;
  logic             o_full;

  assign advance   = !o_valid || rsp.ready;
  assign cmd.ready = (state == S_IDLE) && advance;
  assign accept    = cmd.valid && cmd.ready;
  assign empty     = (count == '0);
  assign full      = (count >= CW'(DEPTH));
  assign hit       = |cell_match;

  // Chain operation for this cycle
  always_comb begin
    op = CELL_HOLD;
    if (accept) begin
      priority if (cmd.mode == MODE_PUSH && !full) begin
        op = CELL_PUSH;
      end else if (cmd.mode == MODE_POP && !empty) begin
        op = CELL_POP;
      end else if (cmd.mode == MODE_DISPLAY && !empty) begin
        op = CELL_ROT;
      end else begin
        op = CELL_HOLD;
      end
    end else if (state == S_DISP && advance) begin
      op = CELL_ROT;
    end
  end

  always_comb begin
    unique case (op)
      CELL_PUSH: count_next = count + 1'b1;
      CELL_POP:  count_next = count - 1'b1;
      default:   count_next = count;
    endcase
  end

  // Cell chain: cell 0 is the top of stack
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctl_t        ctl;
    logic [WordW-1:0] up_w;
    logic [WordW-1:0] down_w;

    assign ctl.op    = op;
    assign ctl.tail  = (count == CW'(i + 1));
    assign ctl.valid = (CW'(i) < count);

    if (i == 0) begin : g_top
      assign up_w = cmd.operand;
    end else begin : g_mid_up
      assign up_w = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_bottom
      assign down_w = cell_data[i];
    end else begin : g_mid_down
      assign down_w = cell_data[i+1];
    end

    alst_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .up_data   (up_w),
      .down_data (down_w),
      .wrap_data (cell_data[0]),
      .key       (cmd.operand),
      .data      (cell_data[i]),
      .match     (cell_match[i])
    );
  end

  // Control state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      rem     <= '0;
      o_valid <= 1'b0;
    end else begin
      count <= count_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            o_valid  <= (cmd.mode <= MODE_DISPLAY);
            o_status <= ST_OK;
            o_data   <= '0;
            o_found  <= 1'b0;
            o_last   <= 1'b1;
            o_depth  <= 4'(count_next);
            o_empty  <= (count_next == '0);
            o_full   <= (count_next >= CW'(DEPTH));
            unique case (cmd.mode)
              MODE_PUSH: begin
                if (full) o_status <= ST_OVERFLOW;
                else      o_data   <= cmd.operand;
              end
              MODE_POP, MODE_PEEK: begin
                if (empty) o_status <= ST_UNDERFLOW;
                else       o_data   <= cell_data[0];
              end
              MODE_SEARCH: begin
                if (empty) o_status <= ST_UNDERFLOW;
                else       o_found  <= hit;
              end
              MODE_DISPLAY: begin
                if (empty) begin
                  o_status <= ST_UNDERFLOW;
                end else begin
                  o_data <= cell_data[0];
                  o_last <= (count == CW'(1));
                  rem    <= count - 1'b1;
                  if (count != CW'(1)) state <= S_DISP;
                end
              end
              default: ;
            endcase
          end else if (rsp.ready) begin
            o_valid <= 1'b0;
          end
        end
        S_DISP: begin
          if (advance) begin
            o_valid <= 1'b1;
            o_data  <= cell_data[0];
            o_last  <= (rem == CW'(1));
            rem     <= rem - 1'b1;
            if (rem == CW'(1)) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid    = o_valid;
  assign rsp.status   = o_status;
  assign rsp.data_out = o_data;
  assign rsp.found    = o_found;
  assign rsp.last     = o_last;
  assign rsp.depth    = o_depth;
  assign rsp.is_empty = o_empty;
  assign rsp.is_full  = o_full;

  `ALS_ASSERT(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH))
  `ALS_ASSERT(a_disp_blocks, clk, rst, state == S_DISP, !cmd.ready)
  `ALS_ASSERT_NEXT(a_disp_keeps_count, clk, rst, state == S_DISP, $stable(count))
  `ALS_ASSERT_NEXT(a_push_grows, clk, rst, op == CELL_PUSH, count == $past(count) + 1'b1)
  `ALS_ASSERT(a_disp_rem_live, clk, rst, state == S_DISP, rem != '0)

endmodule
